### design/bta_pkg.sv
// ----------------------------------------------------------------------------
// bta_pkg
// Shared types, codes and word-format helpers for the boundary-tag allocator.
// ----------------------------------------------------------------------------
package bta_pkg;

  // Offset arithmetic width (room for arena size plus a block total)
  localparam int AW = 22;
  // Width of one offset or size field inside a metadata word
  localparam int FW = 20;
  localparam logic [FW-1:0] NONE = {FW{1'b1}};

  localparam logic [1:0] TAG_HDR = 2'd1;
  localparam logic [1:0] TAG_FTR = 2'd2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ZERO    = 2'd1,
    ST_NOSPACE = 2'd2,
    ST_IGNORED = 2'd3
  } status_t;

  typedef enum logic [5:0] {
    OP_NOP, OP_LOAD, OP_DONE,
    OP_A_START, OP_A_WALK, OP_A_FOUND,
    OP_SP_HDR, OP_SP_FTR, OP_SP_RFTR, OP_NOSPLIT,
    OP_GROW_HDR, OP_GROW_FTR, OP_NOSPACE,
    OP_RM_RDP, OP_RM_WRP, OP_RM_HEADN, OP_RM_RDN, OP_RM_WRN,
    OP_PU_HDR, OP_PU_RDH, OP_PU_WRH, OP_PU_SETH,
    OP_F_RDH, OP_F_BAD, OP_F_MARK, OP_F_RDPF, OP_F_RDPH, OP_F_PFOUND,
    OP_F_PHDR, OP_F_PFTR, OP_F_PCLR, OP_F_RDNX, OP_F_NFOUND,
    OP_F_NHDR, OP_F_NFTR, OP_F_NCLR, OP_F_PUSH
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic is_free_req;
    logic zero_req;
    logic alloc_empty;
    logic fit;
    logic next_none;
    logic do_split;
    logic grow_ok;
    logic rm_p_none;
    logic rm_n_none;
    logic head_none;
    logic f_bad;
    logic hdr_ok;
    logic has_prev;
    logic prev_ok;
    logic nb_free;
    logic nx_in;
    logic out_busy;
  } dp_stat_t;

  function automatic logic [63:0] mk_hdr(logic [FW-1:0] size, logic [FW-1:0] nxt,
                                         logic [FW-1:0] prv, logic fr);
    mk_hdr = {1'b0, TAG_HDR, fr, prv, nxt, size};
  endfunction

  function automatic logic [63:0] mk_ftr(logic [FW-1:0] off);
    mk_ftr = {1'b0, TAG_FTR, 41'd0, off};
  endfunction

endpackage

### design/boundary_tag_heap_allocator.sv
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator
// Boundary-tag heap allocator with a LIFO first-fit explicit free list.
// ----------------------------------------------------------------------------
// One request is worked at a time. Block metadata (headers and footers, one
// 64-bit word per 8-byte granule) lives in a single-port-read, single-port-
// write memory, so every list step costs a memory access: an allocate walks
// the free list one block at a time, then either unlinks the found block and
// splits it if it is large enough, or grows at the top; a free merges with
// whichever neighbors are free. A result that still waits on the master side
// holds the following item in its done state until that result is taken.
// Memory contents are not cleared after reset; only locations already written
// are ever consulted on legal requests. The result register lets the next
// request be accepted while the last result still waits on the master side.
module boundary_tag_heap_allocator #(
  parameter int ARENA_BYTES  = 65536,
  parameter int HEADER_BYTES = 32,
  parameter int FOOTER_BYTES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // alloc_size[15:0], block_addr[31:16]
  input  logic [0:0]  s_tuser,   // req_type[0]: 0 allocate, 1 free
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // result_addr[15:0], status[17:16],
                                 // blocks_in_use[29:18], free_blocks[41:30]
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata  // min_block_size
);
  import bta_pkg::*;

  // Commands flow controller -> datapath, flags flow back
  cmd_t     cmd;
  dp_stat_t stat;

  bta_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bta_datapath #(
    .ARENA_BYTES  (ARENA_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .FOOTER_BYTES (FOOTER_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

### design/bta_datapath.sv
// ----------------------------------------------------------------------------
// bta_datapath
// Metadata memory, allocator registers and result register.
// ----------------------------------------------------------------------------
module bta_datapath #(
  parameter int ARENA_BYTES  = 65536,
  parameter int HEADER_BYTES = 32,
  parameter int FOOTER_BYTES = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  bta_pkg::cmd_t     cmd,
  output bta_pkg::dp_stat_t stat,
  input  logic [31:0]       s_tdata,
  input  logic [0:0]        s_tuser,
  input  logic              cfg_we,
  input  logic [15:0]       cfg_wdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [47:0]       m_tdata
);
  import bta_pkg::*;

  localparam int DEPTH = ARENA_BYTES / 8;
  localparam int GW    = $clog2(DEPTH);
  localparam logic [AW-1:0] HB    = AW'(HEADER_BYTES);
  localparam logic [AW-1:0] FB    = AW'(FOOTER_BYTES);
  localparam logic [AW-1:0] ARENA = AW'(ARENA_BYTES);
  localparam logic [AW-1:0] GRAN  = AW'(8);

  logic [63:0] mem [DEPTH];
  logic [63:0] rdata;
  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [63:0]   wr_data;

  logic          req_free;
  logic [15:0]   asize, baddr, minb;
  logic [AW-1:0] need, top;
  logic [FW-1:0] cur, csize, rm_n, rm_p, h, hsize, ph, phsize, nxsize, poff, psize, head;
  logic [11:0]   bcnt, fcnt;
  status_t       status_q;
  logic [15:0]   result;

  logic [FW-1:0] r_size, r_next, r_prev;
  logic          r_free;
  logic [1:0]    r_tag;
  logic [AW-1:0] need_c, cur_e, h_e, rem, remsize, fh, pnew, nnew, nx, grow_end;

  function automatic logic [AW-1:0] tot(logic [AW-1:0] s);
    tot = s + HB + FB;
  endfunction

  always_comb begin
    r_size = rdata[FW-1:0];
    r_next = rdata[2*FW-1:FW];
    r_prev = rdata[3*FW-1:2*FW];
    r_free = rdata[60];
    r_tag  = rdata[62:61];
    need_c = ((HB + AW'(s_tdata[15:0]) + FB + AW'(7)) & ~AW'(7)) - HB - FB;
    cur_e    = AW'(cur);
    h_e      = AW'(h);
    rem      = cur_e + tot(need);
    remsize  = AW'(csize) - need - HB - FB;
    fh       = AW'(baddr) - HB;
    pnew     = AW'(phsize) + tot(AW'(hsize));
    nnew     = AW'(hsize) + tot(AW'(nxsize));
    nx       = h_e + tot(AW'(hsize));
    grow_end = top + tot(need);
  end

  always_comb begin
    stat.is_free_req = req_free;
    stat.zero_req    = (asize == 16'd0);
    stat.alloc_empty = (fcnt == 12'd0) || (head == NONE);
    stat.fit         = (AW'(r_size) >= need);
    stat.next_none   = (r_next == NONE);
    stat.do_split    = (AW'(csize) - need) >= (HB + AW'(minb) + FB);
    stat.grow_ok     = (grow_end <= ARENA);
    stat.rm_p_none   = (rm_p == NONE);
    stat.rm_n_none   = (rm_n == NONE);
    stat.head_none   = (head == NONE);
    stat.f_bad       = (AW'(baddr) < HB) || (fh[2:0] != 3'd0) || (fh >= top);
    stat.hdr_ok      = (r_tag == TAG_HDR) && !r_free;
    stat.has_prev    = (h_e >= HB + FB);
    stat.prev_ok     = (r_tag == TAG_FTR) && (AW'(r_size) < h_e) && (r_size[2:0] == 3'd0);
    stat.nb_free     = (r_tag == TAG_HDR) && r_free;
    stat.nx_in       = (nx < top) && (nx[2:0] == 3'd0);
    stat.out_busy    = m_tvalid && !m_tready;
  end

  // Memory port selection per command
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    unique case (cmd.op)
      OP_A_START: begin rd_en = 1'b1; rd_addr = AW'(head); end
      OP_A_WALK:  begin rd_en = 1'b1; rd_addr = AW'(r_next); end
      OP_SP_HDR:  begin wr_en = 1'b1; wr_addr = cur_e; wr_data = mk_hdr(FW'(need), NONE, NONE, 1'b0); end
      OP_SP_FTR:  begin wr_en = 1'b1; wr_addr = cur_e + tot(need) - GRAN; wr_data = mk_ftr(cur); end
      OP_SP_RFTR: begin
        wr_en = 1'b1; wr_addr = AW'(poff) + tot(AW'(psize)) - GRAN; wr_data = mk_ftr(poff);
      end
      OP_NOSPLIT: begin wr_en = 1'b1; wr_addr = cur_e; wr_data = mk_hdr(csize, NONE, NONE, 1'b0); end
      OP_GROW_HDR: begin wr_en = 1'b1; wr_addr = top; wr_data = mk_hdr(FW'(need), NONE, NONE, 1'b0); end
      OP_GROW_FTR: begin wr_en = 1'b1; wr_addr = grow_end - GRAN; wr_data = mk_ftr(FW'(top)); end
      OP_RM_RDP:  begin rd_en = 1'b1; rd_addr = AW'(rm_p); end
      OP_RM_WRP:  begin
        wr_en = 1'b1; wr_addr = AW'(rm_p); wr_data = mk_hdr(r_size, rm_n, r_prev, r_free);
      end
      OP_RM_RDN:  begin rd_en = 1'b1; rd_addr = AW'(rm_n); end
      OP_RM_WRN:  begin
        wr_en = 1'b1; wr_addr = AW'(rm_n); wr_data = mk_hdr(r_size, r_next, rm_p, r_free);
      end
      OP_PU_HDR:  begin
        wr_en = 1'b1; wr_addr = AW'(poff); wr_data = mk_hdr(psize, head, NONE, 1'b1);
      end
      OP_PU_RDH:  begin rd_en = 1'b1; rd_addr = AW'(head); end
      OP_PU_WRH:  begin
        wr_en = 1'b1; wr_addr = AW'(head); wr_data = mk_hdr(r_size, r_next, poff, r_free);
      end
      OP_F_RDH:   begin rd_en = 1'b1; rd_addr = fh; end
      OP_F_MARK:  begin wr_en = 1'b1; wr_addr = h_e; wr_data = mk_hdr(r_size, NONE, NONE, 1'b1); end
      OP_F_RDPF:  begin rd_en = 1'b1; rd_addr = h_e - GRAN; end
      OP_F_RDPH:  begin rd_en = 1'b1; rd_addr = AW'(r_size); end
      OP_F_PHDR:  begin
        wr_en = 1'b1; wr_addr = AW'(ph); wr_data = mk_hdr(FW'(pnew), NONE, NONE, 1'b1);
      end
      OP_F_PFTR:  begin wr_en = 1'b1; wr_addr = AW'(ph) + tot(pnew) - GRAN; wr_data = mk_ftr(ph); end
      OP_F_PCLR:  begin wr_en = 1'b1; wr_addr = h_e; wr_data = '0; end
      OP_F_RDNX:  begin rd_en = 1'b1; rd_addr = nx; end
      OP_F_NHDR:  begin
        wr_en = 1'b1; wr_addr = h_e; wr_data = mk_hdr(FW'(nnew), NONE, NONE, 1'b1);
      end
      OP_F_NFTR:  begin wr_en = 1'b1; wr_addr = h_e + tot(nnew) - GRAN; wr_data = mk_ftr(h); end
      OP_F_NCLR:  begin wr_en = 1'b1; wr_addr = nx; wr_data = '0; end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr[GW+2:3]] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr[GW+2:3]];
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        req_free <= s_tuser[0];
        asize    <= s_tdata[15:0];
        baddr    <= s_tdata[31:16];
        need     <= need_c;
        status_q <= (!s_tuser[0] && s_tdata[15:0] == 16'd0) ? ST_ZERO : ST_OK;
        result   <= 16'd0;
      end
      OP_A_START: cur <= head;
      OP_A_WALK:  cur <= r_next;
      OP_A_FOUND: begin rm_n <= r_next; rm_p <= r_prev; csize <= r_size; end
      OP_SP_HDR: begin
        poff   <= FW'(rem);
        psize  <= FW'(remsize);
        result <= 16'(cur_e + HB);
      end
      OP_NOSPLIT:  result <= 16'(cur_e + HB);
      OP_GROW_FTR: result <= 16'(top + HB);
      OP_NOSPACE:  status_q <= ST_NOSPACE;
      OP_F_RDH:    h <= FW'(fh);
      OP_F_BAD:    status_q <= ST_IGNORED;
      OP_F_MARK:   hsize <= r_size;
      OP_F_RDPH:   ph <= r_size;
      OP_F_PFOUND: begin rm_n <= r_next; rm_p <= r_prev; phsize <= r_size; end
      OP_F_PCLR:   begin h <= ph; hsize <= FW'(pnew); end
      OP_F_NFOUND: begin rm_n <= r_next; rm_p <= r_prev; nxsize <= r_size; end
      OP_F_NCLR:   hsize <= FW'(nnew);
      OP_F_PUSH:   begin poff <= h; psize <= hsize; end
      default: begin
      end
    endcase
  end

  // Allocator control state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= NONE;
      top      <= '0;
      bcnt     <= '0;
      fcnt     <= '0;
      minb     <= 16'd1;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        minb <= cfg_wdata;
      end
      if (m_tvalid && m_tready && cmd.op != OP_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (cmd.op)
        OP_A_FOUND:  fcnt <= fcnt - 12'd1;
        OP_SP_HDR:   begin bcnt <= bcnt + 12'd1; fcnt <= fcnt + 12'd1; end
        OP_GROW_FTR: begin top <= grow_end; bcnt <= bcnt + 12'd1; end
        OP_RM_HEADN: head <= rm_n;
        OP_PU_WRH:   head <= poff;
        OP_PU_SETH:  head <= poff;
        OP_F_MARK:   fcnt <= fcnt + 12'd1;
        OP_F_PCLR:   begin bcnt <= bcnt - 12'd1; fcnt <= fcnt - 12'd1; end
        OP_F_NCLR:   begin bcnt <= bcnt - 12'd1; fcnt <= fcnt - 12'd1; end
        OP_DONE: begin
          m_tvalid <= 1'b1;
          m_tdata  <= {6'd0, fcnt, bcnt, status_q, result};
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### design/bta_ctrl.sv
// ----------------------------------------------------------------------------
// bta_ctrl
// Sequencer for allocate and free, with list-remove and list-push routines.
// ----------------------------------------------------------------------------
module bta_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  bta_pkg::dp_stat_t stat,
  output bta_pkg::cmd_t     cmd
);
  import bta_pkg::*;

  typedef enum logic [30:0] {
    S_IDLE = 31'h1,        S_DISP = 31'h2,        S_A0 = 31'h4,          S_A1 = 31'h8,
    S_A2 = 31'h10,         S_A3 = 31'h20,         S_A4 = 31'h40,         S_G0 = 31'h80,
    S_G1 = 31'h100,        S_RM0 = 31'h200,       S_RM1 = 31'h400,       S_RM2 = 31'h800,
    S_RM3 = 31'h1000,      S_PU0 = 31'h2000,      S_PU1 = 31'h4000,      S_PU2 = 31'h8000,
    S_F0 = 31'h10000,      S_F1 = 31'h20000,      S_F2 = 31'h40000,      S_F3 = 31'h80000,
    S_F4 = 31'h100000,     S_F5 = 31'h200000,     S_F6 = 31'h400000,     S_F7 = 31'h800000,
    S_NX0 = 31'h1000000,   S_NX1 = 31'h2000000,   S_NX2 = 31'h4000000,   S_NX3 = 31'h8000000,
    S_NX4 = 31'h10000000,  S_FP = 31'h20000000,   S_DONE = 31'h40000000
  } state_t;

  state_t state, state_next, ret, ret_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ret_next   = ret;
    cmd.op     = OP_NOP;
    unique case (state)
      S_IDLE: if (s_tvalid) begin cmd.op = OP_LOAD; state_next = S_DISP; end
      S_DISP: begin
        if (stat.is_free_req) state_next = S_F0;
        else if (stat.zero_req) state_next = S_DONE;
        else state_next = S_A0;
      end
      S_A0: begin
        if (stat.alloc_empty) state_next = S_G0;
        else begin cmd.op = OP_A_START; state_next = S_A1; end
      end
      S_A1: begin
        if (stat.fit) begin
          cmd.op = OP_A_FOUND; ret_next = S_A2; state_next = S_RM0;
        end else if (stat.next_none) begin
          state_next = S_G0;
        end else begin
          cmd.op = OP_A_WALK;
        end
      end
      S_A2: begin
        if (stat.do_split) begin cmd.op = OP_SP_HDR; state_next = S_A3; end
        else begin cmd.op = OP_NOSPLIT; state_next = S_DONE; end
      end
      S_A3: begin cmd.op = OP_SP_FTR; state_next = S_A4; end
      S_A4: begin cmd.op = OP_SP_RFTR; ret_next = S_DONE; state_next = S_PU0; end
      S_G0: begin
        if (stat.grow_ok) begin cmd.op = OP_GROW_HDR; state_next = S_G1; end
        else begin cmd.op = OP_NOSPACE; state_next = S_DONE; end
      end
      S_G1: begin cmd.op = OP_GROW_FTR; state_next = S_DONE; end
      S_RM0: begin
        if (stat.rm_p_none) begin cmd.op = OP_RM_HEADN; state_next = S_RM2; end
        else begin cmd.op = OP_RM_RDP; state_next = S_RM1; end
      end
      S_RM1: begin cmd.op = OP_RM_WRP; state_next = S_RM2; end
      S_RM2: begin
        if (stat.rm_n_none) state_next = ret;
        else begin cmd.op = OP_RM_RDN; state_next = S_RM3; end
      end
      S_RM3: begin cmd.op = OP_RM_WRN; state_next = ret; end
      S_PU0: begin cmd.op = OP_PU_HDR; state_next = S_PU1; end
      S_PU1: begin
        if (stat.head_none) begin cmd.op = OP_PU_SETH; state_next = ret; end
        else begin cmd.op = OP_PU_RDH; state_next = S_PU2; end
      end
      S_PU2: begin cmd.op = OP_PU_WRH; state_next = ret; end
      S_F0: begin
        if (stat.f_bad) begin cmd.op = OP_F_BAD; state_next = S_DONE; end
        else begin cmd.op = OP_F_RDH; state_next = S_F1; end
      end
      S_F1: begin
        if (stat.hdr_ok) begin cmd.op = OP_F_MARK; state_next = S_F2; end
        else begin cmd.op = OP_F_BAD; state_next = S_DONE; end
      end
      S_F2: begin
        if (stat.has_prev) begin cmd.op = OP_F_RDPF; state_next = S_F3; end
        else state_next = S_NX0;
      end
      S_F3: begin
        if (stat.prev_ok) begin cmd.op = OP_F_RDPH; state_next = S_F4; end
        else state_next = S_NX0;
      end
      S_F4: begin
        if (stat.nb_free) begin
          cmd.op = OP_F_PFOUND; ret_next = S_F5; state_next = S_RM0;
        end else state_next = S_NX0;
      end
      S_F5: begin cmd.op = OP_F_PHDR; state_next = S_F6; end
      S_F6: begin cmd.op = OP_F_PFTR; state_next = S_F7; end
      S_F7: begin cmd.op = OP_F_PCLR; state_next = S_NX0; end
      S_NX0: begin
        if (stat.nx_in) begin cmd.op = OP_F_RDNX; state_next = S_NX1; end
        else state_next = S_FP;
      end
      S_NX1: begin
        if (stat.nb_free) begin
          cmd.op = OP_F_NFOUND; ret_next = S_NX2; state_next = S_RM0;
        end else state_next = S_FP;
      end
      S_NX2: begin cmd.op = OP_F_NHDR; state_next = S_NX3; end
      S_NX3: begin cmd.op = OP_F_NFTR; state_next = S_NX4; end
      S_NX4: begin cmd.op = OP_F_NCLR; state_next = S_FP; end
      S_FP:  begin cmd.op = OP_F_PUSH; ret_next = S_DONE; state_next = S_PU0; end
      S_DONE: if (!stat.out_busy) begin cmd.op = OP_DONE; state_next = S_IDLE; end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_DONE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
    end
  end

  a_accept_disp: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == S_DISP)
    else $error("accepted item did not start dispatch");
  a_done_leaves: assert property (@(posedge clk) disable iff (rst)
    state == S_DONE && !stat.out_busy |=> state == S_IDLE)
    else $error("finished item not released");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_DONE |-> !stat.out_busy)
    else $error("result register overwritten while occupied");

endmodule

### bench/boundary_tag_heap_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator_tb
// Drives allocate and free requests into the allocator and checks every
// result (address, status, block and free-list counts) against a behavioral
// heap model kept inside the bench, across several split thresholds.
// ----------------------------------------------------------------------------
module boundary_tag_heap_allocator_tb;
  import bta_pkg::*;

  localparam int unsigned ARENA = 65536;
  localparam int unsigned HDR = 32;
  localparam int unsigned FTR = 8;
  localparam int unsigned GRANULES = ARENA / 8;
  localparam int unsigned NIL = 32'hFFFFF;
  localparam bit REQ_ALLOC = 1'b0;
  localparam bit REQ_FREE = 1'b1;
  localparam int WATCHDOG_LIMIT = 40000;

  typedef struct packed {
    logic        req;
    logic [15:0] size;
    logic [15:0] addr;
  } heap_req_t;

  typedef struct packed {
    logic [15:0] addr;
    status_t     status;
    logic [11:0] blocks;
    logic [11:0] frees;
  } heap_rsp_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // alloc_size[15:0], block_addr[31:16]
  logic [0:0]  s_tuser;   // req_type[0]
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // result_addr[15:0], status[17:16], blocks[29:18], free[41:30]
  logic        cfg_we;
  logic [15:0] cfg_wdata;

  boundary_tag_heap_allocator u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // --------------------------------------------------------------------------
  // Heap model: one metadata word per 8-byte granule, plus a written mark so
  // that stimulus never makes the design look at a granule it never wrote.
  // Header word: size[19:0] next[39:20] prev[59:40] free[60] tag[62:61].
  // --------------------------------------------------------------------------
  logic [63:0] heap_meta [GRANULES];
  bit          heap_written [GRANULES];
  int unsigned fl_head;
  int unsigned heap_top;
  int unsigned blk_cnt;
  int unsigned free_cnt;
  int unsigned min_split;

  int unsigned live_addrs [$];   // payloads of blocks currently allocated
  int unsigned dead_addrs [$];   // payloads freed at some point

  function automatic logic [63:0] meta_rd(int unsigned off);
    if (off / 8 < GRANULES) return heap_meta[off / 8];
    return 64'd0;
  endfunction

  function automatic void meta_wr(int unsigned off, logic [63:0] v);
    if (off / 8 < GRANULES) begin
      heap_meta[off / 8] = v;
      heap_written[off / 8] = 1'b1;
    end
  endfunction

  function automatic logic [63:0] hdr_word(int unsigned sz, int unsigned nx,
                                           int unsigned pv, bit fr);
    logic [19:0] s20, n20, p20;
    s20 = sz[19:0];
    n20 = nx[19:0];
    p20 = pv[19:0];
    return {1'b0, TAG_HDR, fr, p20, n20, s20};
  endfunction

  function automatic int unsigned f_size(logic [63:0] w); return {12'd0, w[19:0]}; endfunction
  function automatic int unsigned f_next(logic [63:0] w); return {12'd0, w[39:20]}; endfunction
  function automatic int unsigned f_prev(logic [63:0] w); return {12'd0, w[59:40]}; endfunction
  function automatic logic [1:0] f_tag(logic [63:0] w); return w[62:61]; endfunction
  function automatic bit f_free(logic [63:0] w); return w[60]; endfunction
  function automatic int unsigned span(int unsigned p); return HDR + p + FTR; endfunction

  function automatic bit at_header(int unsigned off);
    return (off % 8 == 0) && off < heap_top && f_tag(meta_rd(off)) == TAG_HDR;
  endfunction

  function automatic void put_block(int unsigned off, int unsigned sz, bit fr);
    logic [19:0] o20;
    o20 = off[19:0];
    meta_wr(off, hdr_word(sz, NIL, NIL, fr));
    meta_wr(off + span(sz) - 8, {1'b0, TAG_FTR, 41'd0, o20});
  endfunction

  function automatic void link_next(int unsigned off, int unsigned n);
    logic [63:0] w;
    w = meta_rd(off);
    meta_wr(off, hdr_word(f_size(w), n, f_prev(w), w[60]));
  endfunction

  function automatic void link_prev(int unsigned off, int unsigned p);
    logic [63:0] w;
    w = meta_rd(off);
    meta_wr(off, hdr_word(f_size(w), f_next(w), p, w[60]));
  endfunction

  function automatic void unlink(int unsigned off);
    logic [63:0] w;
    int unsigned n, p;
    w = meta_rd(off);
    n = f_next(w);
    p = f_prev(w);
    if (p != NIL) link_next(p, n);
    else fl_head = n;
    if (n != NIL) link_prev(n, p);
    meta_wr(off, hdr_word(f_size(w), NIL, NIL, w[60]));
  endfunction

  function automatic void push_head(int unsigned off);
    logic [63:0] w;
    w = meta_rd(off);
    meta_wr(off, hdr_word(f_size(w), fl_head, NIL, w[60]));
    if (fl_head != NIL) link_prev(fl_head, off);
    fl_head = off;
  endfunction

  // First-fit walk, split or grow; returns payload offset or 0.
  function automatic int unsigned model_alloc(int unsigned sz, output status_t st);
    int unsigned need, cur, csize, rem;
    logic [63:0] w;
    st = ST_OK;
    need = ((span(sz) + 7) & ~32'd7) - HDR - FTR;
    cur = fl_head;
    if (free_cnt != 0) begin
      for (int i = 0; cur != NIL && i < GRANULES; i++) begin
        w = meta_rd(cur);
        csize = f_size(w);
        if (csize < need) begin
          cur = f_next(w);
          continue;
        end
        unlink(cur);
        free_cnt--;
        if (csize - need >= span(min_split)) begin
          rem = cur + span(need);
          put_block(cur, need, 1'b0);
          put_block(rem, csize - need - HDR - FTR, 1'b1);
          blk_cnt++;
          push_head(rem);
          free_cnt++;
        end else begin
          meta_wr(cur, hdr_word(csize, NIL, NIL, 1'b0));
        end
        return cur + HDR;
      end
    end
    if (heap_top + span(need) <= ARENA) begin
      cur = heap_top;
      put_block(cur, need, 1'b0);
      heap_top += span(need);
      blk_cnt++;
      return cur + HDR;
    end
    st = ST_NOSPACE;
    return 0;
  endfunction

  // Mark free, merge with free neighbors on both sides, push on the list.
  function automatic status_t model_free(int unsigned p);
    int unsigned h, ph, nx;
    logic [63:0] w, fw;
    if (p < HDR) return ST_IGNORED;
    h = p - HDR;
    if (!at_header(h)) return ST_IGNORED;
    w = meta_rd(h);
    if (w[60]) return ST_IGNORED;
    meta_wr(h, hdr_word(f_size(w), NIL, NIL, 1'b1));
    free_cnt++;
    if (h >= span(0)) begin
      fw = meta_rd(h - 8);
      if (fw[62:61] == TAG_FTR) begin
        ph = {12'd0, fw[19:0]};
        if (ph < h && at_header(ph) && f_free(meta_rd(ph))) begin
          unlink(ph);
          put_block(ph, f_size(meta_rd(ph)) + span(f_size(meta_rd(h))), 1'b1);
          meta_wr(h, 64'd0);
          h = ph;
          blk_cnt--;
          free_cnt--;
        end
      end
    end
    nx = h + span(f_size(meta_rd(h)));
    if (nx < heap_top && at_header(nx) && f_free(meta_rd(nx))) begin
      unlink(nx);
      put_block(h, f_size(meta_rd(h)) + span(f_size(meta_rd(nx))), 1'b1);
      meta_wr(nx, 64'd0);
      blk_cnt--;
      free_cnt--;
    end
    push_head(h);
    return ST_OK;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus and expectation stores
  // --------------------------------------------------------------------------
  heap_req_t pending_reqs [$];
  heap_rsp_t expected_rsps [$];
  int        errors;
  bit        no_idle;
  int        stall_cycles;

  // Predict one request, queue it for the driver and its result for checking.
  function automatic int unsigned issue(bit req, int unsigned sz, int unsigned addr);
    heap_req_t r;
    heap_rsp_t e;
    status_t   st;
    int unsigned res;
    res = 0;
    if (req == REQ_ALLOC) begin
      if (sz == 0) st = ST_ZERO;
      else res = model_alloc(sz, st);
      if (st == ST_OK) live_addrs.push_back(res);
    end else begin
      st = model_free(addr);
      if (st == ST_OK) begin
        foreach (live_addrs[i]) begin
          if (live_addrs[i] == addr) begin
            live_addrs.delete(i);
            break;
          end
        end
        dead_addrs.push_back(addr);
      end
    end
    r.req = req;
    r.size = sz[15:0];
    r.addr = addr[15:0];
    e.addr = res[15:0];
    e.status = st;
    e.blocks = blk_cnt[11:0];
    e.frees = free_cnt[11:0];
    pending_reqs.push_back(r);
    expected_rsps.push_back(e);
    return res;
  endfunction

  // A free target the design may look up: anything whose header granule is
  // either out of the block range, misaligned, below the first payload, or
  // already written.
  function automatic bit safe_target(int unsigned p);
    if (p < HDR || (p - HDR) % 8 != 0 || p - HDR >= heap_top) return 1'b1;
    return heap_written[(p - HDR) / 8];
  endfunction

  function automatic int unsigned pick_target();
    int unsigned sel, p;
    sel = $urandom_range(0, 99);
    if (sel < 65 && live_addrs.size() != 0)
      return live_addrs[$urandom_range(0, live_addrs.size() - 1)];
    if (sel < 82 && dead_addrs.size() != 0)
      return dead_addrs[$urandom_range(0, dead_addrs.size() - 1)];
    p = $urandom_range(0, 65535);
    return safe_target(p) ? p : 0;
  endfunction

  function automatic int unsigned pick_size();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 3) return 0;
    if (sel < 70) return $urandom_range(1, 96);
    if (sel < 94) return $urandom_range(97, 1200);
    return $urandom_range(1201, 65535);
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || s_tvalid)
      @(posedge clk);
  endtask

  task automatic set_split_min(int unsigned v);
    wait_drained();
    repeat (64) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    min_split = v;
  endtask

  task automatic run_random(int n);
    int unsigned free_bias;
    for (int k = 0; k < n; k++) begin
      while (pending_reqs.size() > 8) @(posedge clk);
      // lean toward frees as the arena fills so it keeps churning
      free_bias = 35 + (heap_top * 40) / ARENA;
      if ($urandom_range(0, 99) < free_bias) void'(issue(REQ_FREE, 0, pick_target()));
      else void'(issue(REQ_ALLOC, pick_size(), $urandom_range(0, 65535)));
    end
  endtask

  // --------------------------------------------------------------------------
  // Driver: advance to the next pending item on acceptance, idle at random.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (pending_reqs.size() != 0 && (no_idle || $urandom_range(0, 99) >= 33)) begin
        heap_req_t r;
        r = pending_reqs.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= r.req;
        s_tdata <= {r.addr, r.size};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: stall the result side at random and check each accepted item.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: unexpected result got %h", $time, m_tdata);
          errors++;
        end else begin
          heap_rsp_t e;
          e = expected_rsps.pop_front();
          if (m_tdata[15:0] !== e.addr) begin
            $display("%0t: result_addr expected %h actual %h", $time, e.addr, m_tdata[15:0]);
            errors++;
          end
          if (m_tdata[17:16] !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, m_tdata[17:16]);
            errors++;
          end
          if (m_tdata[29:18] !== e.blocks) begin
            $display("%0t: blocks_in_use expected %0d actual %0d", $time, e.blocks,
                     m_tdata[29:18]);
            errors++;
          end
          if (m_tdata[41:30] !== e.frees) begin
            $display("%0t: free_blocks expected %0d actual %0d", $time, e.frees,
                     m_tdata[41:30]);
            errors++;
          end
        end
      end
      m_tready <= no_idle || $urandom_range(0, 99) >= 33;
    end
  end

  // Watchdog: count cycles with no item moving on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else if (pending_reqs.size() != 0 || expected_rsps.size() != 0) begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("boundary_tag_heap_allocator verification failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned a, b, c, d, big;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    errors = 0;
    no_idle = 1'b0;
    stall_cycles = 0;
    fl_head = NIL;
    heap_top = 0;
    blk_cnt = 0;
    free_cnt = 0;
    min_split = 1;
    foreach (heap_meta[i]) begin
      heap_meta[i] = 64'd0;
      heap_written[i] = 1'b0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    set_split_min(1);

    // Directed: zero size, oversize, whole arena, bad and repeated frees.
    void'(issue(REQ_ALLOC, 0, 0));
    void'(issue(REQ_ALLOC, 65535, 16'hFFFF));
    big = issue(REQ_ALLOC, 65488, 0);
    void'(issue(REQ_ALLOC, 1, 0));
    void'(issue(REQ_FREE, 0, big));
    void'(issue(REQ_FREE, 0, big));
    void'(issue(REQ_FREE, 0, 0));
    void'(issue(REQ_FREE, 0, 65535));
    void'(issue(REQ_FREE, 0, 33));
    // Split from the big free block, then coalesce on both sides.
    a = issue(REQ_ALLOC, 16, 0);
    b = issue(REQ_ALLOC, 8, 0);
    c = issue(REQ_ALLOC, 100, 0);
    d = issue(REQ_ALLOC, 40, 0);
    void'(issue(REQ_FREE, 0, a));
    void'(issue(REQ_FREE, 0, c));
    void'(issue(REQ_FREE, 0, b));
    void'(issue(REQ_ALLOC, 7, 0));
    void'(issue(REQ_FREE, 0, d));
    void'(issue(REQ_ALLOC, 65535, 0));

    // Random phases across thresholds; hold the sender until all results land
    // before each register write.
    no_idle = 1'b1;
    run_random(200);
    no_idle = 1'b0;
    run_random(150);
    set_split_min(65535);
    run_random(330);
    set_split_min(8);
    run_random(330);
    set_split_min($urandom_range(2, 600));
    run_random(330);
    set_split_min(1);
    run_random(330);

    wait_drained();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("boundary_tag_heap_allocator verification clean");
    end else begin
      $display("boundary_tag_heap_allocator verification failed");
    end
    $finish;
  end

endmodule

### boundary_tag_heap_allocator.f
design/bta_pkg.sv
design/bta_datapath.sv
design/bta_ctrl.sv
design/boundary_tag_heap_allocator.sv
bench/boundary_tag_heap_allocator_tb.sv
